@@ src/pfd_pkg.sv @@
// Shared types, constants and helpers for the page frame store drawing block.
package pfd_pkg;

  // Default screen geometry.
  localparam int unsigned SCREEN_COLUMNS_DEF = 128;
  localparam int unsigned SCREEN_ROWS_DEF    = 64;

  // Job fields are sized for the largest legal geometry (256 columns, 32 pages).
  localparam int unsigned COL_W  = 8;
  localparam int unsigned PAGE_W = 5;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } pfd_cmd_e;

  typedef enum logic [1:0] {
    JOB_NOP   = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_READ  = 2'd2
  } pfd_job_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WALK  = 3'd2,
    ST_DONE  = 3'd3,
    ST_READ  = 3'd4
  } pfd_state_e;

  // One classified command: clipped column/page span plus the row bits that
  // bound the mask on the first and last page.
  typedef struct packed {
    pfd_job_e          kind;
    logic              ink;
    logic [COL_W-1:0]  c0;
    logic [COL_W-1:0]  c1;
    logic [PAGE_W-1:0] p0;
    logic [PAGE_W-1:0] p1;
    logic [2:0]        top_bit;
    logic [2:0]        bot_bit;
  } pfd_job_t;

  // Bits lo..hi (inclusive) set.
  function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
    return (8'hff << lo) & (8'hff >> (3'd7 - hi));
  endfunction

endpackage

@@ src/pfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pfd_front.sv @@
// Command classifier: clips points, rectangles and reads into a job.
module pfd_front #(
  parameter int unsigned SCREEN_COLUMNS = pfd_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = pfd_pkg::SCREEN_ROWS_DEF
) (
  input  logic [1:0]        command_i,
  input  logic signed [8:0] column_i,
  input  logic [7:0]        row_i,
  input  logic [7:0]        rect_height_i,
  input  logic [7:0]        rect_width_i,
  input  logic              ink_i,
  output pfd_pkg::pfd_job_t job_o
);

  localparam int unsigned PAGES = (SCREEN_ROWS + 7) / 8;

  logic              col_neg;
  logic              col_in;
  logic              row_in;
  logic              page_in;
  logic signed [9:0] col_s;
  logic signed [9:0] col_end;
  logic signed [9:0] col_hi;
  logic signed [9:0] col_last;
  logic [7:0]        col_lo;
  logic [8:0]        row_end;
  logic [8:0]        row_hi;
  logic [8:0]        row_last;
  logic              fill_ok;

  assign col_neg = column_i[8];
  assign col_s   = {column_i[8], column_i};
  assign col_in  = !col_neg && ({1'b0, column_i[7:0]} < 9'(SCREEN_COLUMNS));
  assign row_in  = {1'b0, row_i} < 9'(SCREEN_ROWS);
  assign page_in = {1'b0, row_i[7:3]} < 6'(PAGES);

  // Rectangle clip: [col_lo, col_hi) x [row_i, row_hi)
  assign col_end  = col_s + $signed({2'b00, rect_width_i});
  assign col_hi   = (col_end > $signed(10'(SCREEN_COLUMNS))) ? $signed(10'(SCREEN_COLUMNS))
                                                             : col_end;
  assign col_lo   = col_neg ? 8'd0 : column_i[7:0];
  assign col_last = col_hi - 10'sd1;
  assign row_end  = {1'b0, row_i} + {1'b0, rect_height_i};
  assign row_hi   = (row_end > 9'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS) : row_end;
  assign row_last = row_hi - 9'd1;
  assign fill_ok  = ($signed({2'b00, col_lo}) < col_hi) && ({1'b0, row_i} < row_hi);

  always_comb begin
    job_o     = '0;
    job_o.ink = ink_i;
    unique case (pfd_pkg::pfd_cmd_e'(command_i))
      pfd_pkg::CMD_POINT: begin
        if (col_in && row_in) begin
          job_o.kind    = pfd_pkg::JOB_WRITE;
          job_o.c0      = column_i[7:0];
          job_o.c1      = column_i[7:0];
          job_o.p0      = row_i[7:3];
          job_o.p1      = row_i[7:3];
          job_o.top_bit = row_i[2:0];
          job_o.bot_bit = row_i[2:0];
        end
      end
      pfd_pkg::CMD_FILL: begin
        if (fill_ok) begin
          job_o.kind    = pfd_pkg::JOB_WRITE;
          job_o.c0      = col_lo;
          job_o.c1      = col_last[7:0];
          job_o.p0      = row_i[7:3];
          job_o.p1      = row_last[7:3];
          job_o.top_bit = row_i[2:0];
          job_o.bot_bit = row_last[2:0];
        end
      end
      pfd_pkg::CMD_READ: begin
        if (col_in && page_in) begin
          job_o.kind = pfd_pkg::JOB_READ;
          job_o.c0   = column_i[7:0];
          job_o.p0   = row_i[7:3];
        end
      end
      pfd_pkg::CMD_NONE: begin
        job_o.kind = pfd_pkg::JOB_NOP;
      end
      default: begin
        job_o.kind = pfd_pkg::JOB_NOP;
      end
    endcase
  end

endmodule

@@ src/pfd_queue.sv @@
// Short job queue between the classifier and the store sequencer.
module pfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfd_pkg::pfd_job_t job_i,
  input  logic              pop_i,
  output pfd_pkg::pfd_job_t job_o,
  output logic              valid_o,
  output logic              full_o
);

  localparam int unsigned QD    = pfd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CNT_W = $clog2(QD + 1);

  pfd_pkg::pfd_job_t slot_q [QD];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == CNT_W'(QD);
  assign valid_o = cnt_q != '0;
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/pfd_back.sv @@
// Store sequencer: clears the store, walks fills byte by byte, serves reads.
module pfd_back #(
  parameter int unsigned SCREEN_COLUMNS = pfd_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = pfd_pkg::SCREEN_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfd_pkg::pfd_job_t job_i,
  input  logic              job_valid_i,
  output logic              pop_o,
  output logic              ready_o,
  output logic              result_valid_o,
  output logic [7:0]        read_data_o,
  output logic              touched_o,
  output logic [6:0]        first_column_o,
  output logic [6:0]        last_column_o,
  output logic [2:0]        first_page_o,
  output logic [2:0]        last_page_o
);

  localparam int unsigned PAGES = (SCREEN_ROWS + 7) / 8;
  localparam int unsigned DEPTH = SCREEN_COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] byte_addr(input logic [pfd_pkg::COL_W-1:0]  c,
                                              input logic [pfd_pkg::PAGE_W-1:0] p);
    return AW'(c) * AW'(PAGES) + AW'(p);
  endfunction

  pfd_pkg::pfd_state_e             state_q, state_d;
  logic [AW-1:0]                   clr_q, clr_d;
  pfd_pkg::pfd_job_t               job_q, job_d;
  logic [pfd_pkg::COL_W-1:0]       col_q, col_d;
  logic [pfd_pkg::PAGE_W-1:0]      page_q, page_d;
  logic                            wr_vld_q, wr_vld_d;
  logic [AW-1:0]                   wr_addr_q, wr_addr_d;
  logic [7:0]                      wr_mask_q, wr_mask_d;
  logic                            res_vld_q, res_vld_d;
  logic [7:0]                      res_data_q, res_data_d;
  logic                            res_touch_q, res_touch_d;
  logic [6:0]                      res_c0_q, res_c0_d, res_c1_q, res_c1_d;
  logic [2:0]                      res_p0_q, res_p0_d, res_p1_q, res_p1_d;

  logic          walk_last;
  logic [7:0]    cur_mask;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign walk_last = (col_q == job_q.c1) && (page_q == job_q.p1);
  assign cur_mask  = pfd_pkg::page_mask((page_q == job_q.p0) ? job_q.top_bit : 3'd0,
                                        (page_q == job_q.p1) ? job_q.bot_bit : 3'd7);

  pfd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfd_pkg::ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = pfd_pkg::ST_IDLE;
      pfd_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == pfd_pkg::JOB_WRITE) begin
            state_d = pfd_pkg::ST_WALK;
          end else if (job_i.kind == pfd_pkg::JOB_READ) begin
            state_d = pfd_pkg::ST_READ;
          end
        end
      end
      pfd_pkg::ST_WALK: if (walk_last) state_d = pfd_pkg::ST_DONE;
      pfd_pkg::ST_DONE: state_d = pfd_pkg::ST_IDLE;
      pfd_pkg::ST_READ: state_d = pfd_pkg::ST_IDLE;
      default:          state_d = pfd_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    pop_o       = 1'b0;
    clr_d       = clr_q;
    job_d       = job_q;
    col_d       = col_q;
    page_d      = page_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_mask_d   = wr_mask_q;
    res_vld_d   = 1'b0;
    res_data_d  = 8'd0;
    res_touch_d = 1'b0;
    res_c0_d    = 7'd0;
    res_c1_d    = 7'd0;
    res_p0_d    = 3'd0;
    res_p1_d    = 3'd0;
    ram_raddr   = byte_addr(col_q, page_q);
    ram_we      = wr_vld_q;
    ram_waddr   = wr_addr_q;
    ram_wdata   = job_q.ink ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);
    unique case (state_q)
      pfd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'd0;
        clr_d     = clr_q + AW'(1);
      end
      pfd_pkg::ST_IDLE: begin
        ram_raddr = byte_addr(job_i.c0, job_i.p0);
        if (job_valid_i) begin
          pop_o  = 1'b1;
          job_d  = job_i;
          col_d  = job_i.c0;
          page_d = job_i.p0;
          // nothing to do for a clipped-away or unused command: answer now
          if (job_i.kind != pfd_pkg::JOB_WRITE && job_i.kind != pfd_pkg::JOB_READ) begin
            res_vld_d = 1'b1;
          end
        end
      end
      pfd_pkg::ST_WALK: begin
        wr_vld_d  = 1'b1;
        wr_addr_d = byte_addr(col_q, page_q);
        wr_mask_d = cur_mask;
        if (col_q == job_q.c1) begin
          col_d  = job_q.c0;
          page_d = page_q + pfd_pkg::PAGE_W'(1);
        end else begin
          col_d = col_q + pfd_pkg::COL_W'(1);
        end
      end
      pfd_pkg::ST_DONE: begin
        res_vld_d   = 1'b1;
        res_touch_d = 1'b1;
        res_c0_d    = job_q.c0[6:0];
        res_c1_d    = job_q.c1[6:0];
        res_p0_d    = job_q.p0[2:0];
        res_p1_d    = job_q.p1[2:0];
      end
      pfd_pkg::ST_READ: begin
        res_vld_d  = 1'b1;
        res_data_d = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfd_pkg::ST_CLEAR;
      clr_q     <= '0;
      wr_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_vld_q  <= wr_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    col_q       <= col_d;
    page_q      <= page_d;
    wr_addr_q   <= wr_addr_d;
    wr_mask_q   <= wr_mask_d;
    res_data_q  <= res_data_d;
    res_touch_q <= res_touch_d;
    res_c0_q    <= res_c0_d;
    res_c1_q    <= res_c1_d;
    res_p0_q    <= res_p0_d;
    res_p1_q    <= res_p1_d;
  end

  assign ready_o        = state_q != pfd_pkg::ST_CLEAR;
  assign result_valid_o = res_vld_q;
  assign read_data_o    = res_data_q;
  assign touched_o      = res_touch_q;
  assign first_column_o = res_c0_q;
  assign last_column_o  = res_c1_q;
  assign first_page_o   = res_p0_q;
  assign last_page_o    = res_p1_q;

endmodule

@@ src/page_framebuffer_draw.sv @@
// Top level of the page-organized monochrome frame store with point, fill and read.
// Order: a command is queued on transfer and popped when the sequencer is idle; one that writes
//   nothing then answers, a read after its store read, a point or fill after its clipped walk.
// Throughput: one store byte per cycle, one command at a time; a 2-entry queue takes new ones.
// Reset: the store is cleared one byte per cycle, all SCREEN_COLUMNS*((SCREEN_ROWS+7)/8)
//   bytes (1024 by default), with busy high throughout. Results cannot be stalled.
module page_framebuffer_draw #(
  parameter int unsigned SCREEN_COLUMNS = pfd_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = pfd_pkg::SCREEN_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic signed [8:0] column_i,
  input  logic [7:0]        row_i,
  input  logic [7:0]        rect_height_i,
  input  logic [7:0]        rect_width_i,
  input  logic              ink_i,
  // result channel, one cycle per result
  output logic              result_valid_o,
  output logic [7:0]        read_data_o,
  output logic              touched_o,
  output logic [6:0]        first_column_o,
  output logic [6:0]        last_column_o,
  output logic [2:0]        first_page_o,
  output logic [2:0]        last_page_o
);

  pfd_pkg::pfd_job_t new_job;
  pfd_pkg::pfd_job_t head_job;
  logic              head_valid;
  logic              queue_full;
  logic              head_pop;
  logic              back_ready;
  logic              cmd_xfer;

  // A transfer happens when the queue has room and the store clear is over.
  assign busy     = queue_full || !back_ready;
  assign cmd_xfer = start && !busy;

  // Front: clip and classify the command on the transfer cycle.
  pfd_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .command_i    (command_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .rect_height_i(rect_height_i),
    .rect_width_i (rect_width_i),
    .ink_i        (ink_i),
    .job_o        (new_job)
  );

  pfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_xfer),
    .job_i  (new_job),
    .pop_i  (head_pop),
    .job_o  (head_job),
    .valid_o(head_valid),
    .full_o (queue_full)
  );

  // Back: read-modify-write walk over the store, one byte per cycle.
  pfd_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_valid_i   (head_valid),
    .pop_o         (head_pop),
    .ready_o       (back_ready),
    .result_valid_o(result_valid_o),
    .read_data_o   (read_data_o),
    .touched_o     (touched_o),
    .first_column_o(first_column_o),
    .last_column_o (last_column_o),
    .first_page_o  (first_page_o),
    .last_page_o   (last_page_o)
  );

endmodule

@@ src/pfd_checker.sv @@
// Port-level checks for the frame store drawing block, bound to the top level.
module pfd_checker #(
  parameter int unsigned SCREEN_COLUMNS = pfd_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = pfd_pkg::SCREEN_ROWS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic [7:0] read_data_o,
  input logic       touched_o,
  input logic [6:0] first_column_o,
  input logic [6:0] last_column_o,
  input logic [2:0] first_page_o,
  input logic [2:0] last_page_o
);

  // An untouched result carries an all-zero span.
  a_untouched_span_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !touched_o |->
      first_column_o == 7'd0 && last_column_o == 7'd0 &&
      first_page_o == 3'd0 && last_page_o == 3'd0)
    else $error("untouched result with nonzero span");

  // Writes never return read data.
  a_write_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && touched_o |-> read_data_o == 8'd0)
    else $error("write result carries read data");

  // Column span ordered (only meaningful when columns fit the port width).
  a_column_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SCREEN_COLUMNS <= 128) && result_valid_o && touched_o |->
      first_column_o <= last_column_o)
    else $error("column span reversed");

  // Page span ordered (only meaningful when pages fit the port width).
  a_page_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SCREEN_ROWS <= 64) && result_valid_o && touched_o |->
      first_page_o <= last_page_o)
    else $error("page span reversed");

endmodule

bind page_framebuffer_draw pfd_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_ROWS   (SCREEN_ROWS)
) u_pfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .result_valid_o(result_valid_o),
  .read_data_o   (read_data_o),
  .touched_o     (touched_o),
  .first_column_o(first_column_o),
  .last_column_o (last_column_o),
  .first_page_o  (first_page_o),
  .last_page_o   (last_page_o)
);
